// ===== rtl/core/utf8d_pkg.sv =====
// utf8d_pkg: word types, status codes and byte constants of the UTF-8 byte decoder
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package utf8d_pkg;

    // input word: one raw byte and its end-of-buffer mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // result word: one decoded character or one error report
    typedef struct packed {
        logic [30:0] code_point;
        logic [1:0]  status;
        logic [2:0]  byte_count;
    } out_word_t;

    // partial sequence held between bytes
    typedef struct packed {
        logic [2:0]  expected_length;
        logic [2:0]  bytes_taken;
        logic [30:0] partial_value;
        logic        sequence_bad;
    } seq_state_t;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ILLEGAL   = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;
    localparam logic [2:0] LEN_5    = 3'd5;
    localparam logic [2:0] LEN_6    = 3'd6;

    // lead byte boundaries and overlong limits on the second byte
    localparam logic [7:0] ASCII_END   = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC2;
    localparam logic [7:0] LEAD_4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_5_MIN  = 8'hF8;
    localparam logic [7:0] LEAD_6_MIN  = 8'hFC;
    localparam logic [7:0] LEAD_END    = 8'hFE;
    localparam logic [7:0] OVER_4_MIN  = 8'h90;
    localparam logic [7:0] OVER_5_MIN  = 8'h88;
    localparam logic [7:0] OVER_6_MIN  = 8'h84;
    localparam logic [1:0] CONT_TAG    = 2'b10;
    localparam logic [2:0] LEAD_2_TAG  = 3'b110;
    localparam logic [3:0] LEAD_3_TAG  = 4'b1110;

endpackage

// ===== rtl/core/utf8d_in_stage.sv =====
// utf8d_in_stage: input register of the UTF-8 byte decoder
// depends on utf8d_pkg for the input word type
`timescale 1ns / 1ps

module utf8d_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  utf8d_pkg::in_word_t s_data,
    input  logic                advance,
    output logic                hold_valid,
    output utf8d_pkg::in_word_t hold_data
);
    import utf8d_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t data_reg;

    // free when empty or when the held word moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

// ===== rtl/core/utf8d_core.sv =====
// utf8d_core: partial sequence state and single-pass byte decode
// depends on utf8d_pkg for word types, state type and constants
`timescale 1ns / 1ps

module utf8d_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  utf8d_pkg::in_word_t  in_word,
    output logic                 res_valid,
    output utf8d_pkg::out_word_t res_word
);
    import utf8d_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    seq_state_t closed;

    logic [7:0] b;
    logic       last;
    logic [2:0] taken_inc;
    logic       cont_bad;
    logic       overlong;
    logic       bad_any;
    logic [30:0] part_shift;

    assign b    = in_word.data_byte;
    assign last = in_word.last_byte;

    assign closed = '{expected_length: LEN_NONE, bytes_taken: 3'd0,
                      partial_value: 31'd0, sequence_bad: 1'b0};

    // continuation tests
    assign cont_bad  = (b[7:6] != CONT_TAG);
    assign overlong  = (state_reg.bytes_taken == LEN_1) && (state_reg.partial_value == 31'd0)
                       && (((state_reg.expected_length == LEN_4) && (b < OVER_4_MIN))
                        || ((state_reg.expected_length == LEN_5) && (b < OVER_5_MIN))
                        || ((state_reg.expected_length == LEN_6) && (b < OVER_6_MIN)));
    assign bad_any    = state_reg.sequence_bad || cont_bad || overlong;
    assign part_shift = {state_reg.partial_value[24:0], b[5:0]};
    assign taken_inc  = state_reg.bytes_taken + 3'd1;

    // next state and result
    always_comb begin
        state_next = state_reg;
        res_valid  = 1'b0;
        res_word   = '{code_point: 31'd0, status: ST_OK, byte_count: LEN_1};
        if (state_reg.expected_length == LEN_NONE) begin
            priority if (b < ASCII_END) begin
                res_valid           = 1'b1;
                res_word.code_point = {23'd0, b};
            end else if (b < LEAD_MIN || b >= LEAD_END) begin
                res_valid       = 1'b1;
                res_word.status = ST_ILLEGAL;
            end else if (last) begin
                res_valid       = 1'b1;
                res_word.status = ST_TRUNCATED;
                state_next      = closed;
            end else begin
                state_next.bytes_taken  = LEN_1;
                state_next.sequence_bad = 1'b0;
                priority if (b[7:5] == LEAD_2_TAG) begin
                    state_next.expected_length = LEN_2;
                    state_next.partial_value   = {26'd0, b[4:0]};
                end else if (b[7:4] == LEAD_3_TAG) begin
                    state_next.expected_length = LEN_3;
                    state_next.partial_value   = {27'd0, b[3:0]};
                end else if (b < LEAD_5_MIN) begin
                    state_next.expected_length = LEN_4;
                    state_next.partial_value   = {28'd0, b[2:0]};
                end else if (b < LEAD_6_MIN) begin
                    state_next.expected_length = LEN_5;
                    state_next.partial_value   = {29'd0, b[1:0]};
                end else begin
                    state_next.expected_length = LEN_6;
                    state_next.partial_value   = {30'd0, b[0]};
                end
            end
        end else begin
            priority if (taken_inc >= state_reg.expected_length) begin
                res_valid           = 1'b1;
                res_word.byte_count = state_reg.expected_length;
                res_word.status     = bad_any ? ST_BAD : ST_OK;
                res_word.code_point = bad_any ? 31'd0 : part_shift;
                state_next          = closed;
            end else if (last) begin
                res_valid           = 1'b1;
                res_word.byte_count = taken_inc;
                res_word.status     = ST_TRUNCATED;
                state_next          = closed;
            end else begin
                state_next.bytes_taken   = taken_inc;
                state_next.partial_value = part_shift;
                state_next.sequence_bad  = bad_any;
            end
        end
    end

    // sequence state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= closed;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/utf8d_out_stage.sv =====
// utf8d_out_stage: result register of the UTF-8 byte decoder
// depends on utf8d_pkg for the result word type
`timescale 1ns / 1ps

module utf8d_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic                 res_valid,
    input  utf8d_pkg::out_word_t res_word,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output utf8d_pkg::out_word_t m_data
);
    import utf8d_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t data_reg;

    // free when empty or when the held word is taken this cycle
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? res_valid : (valid_reg && !m_ready);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            data_reg <= res_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/core/utf8_byte_decoder.sv =====
// utf8_byte_decoder: streaming UTF-8 decoder, one byte word per cycle unless stalled
// a result word enters the result register as its last byte leaves the input register
// one byte word per cycle unless stalled, set by one decode pass between two registers
// bytes that only extend an open sequence give no result word
// reset: synchronous active-low aresetn empties both registers and closes any sequence
// depends on utf8d_pkg, utf8d_in_stage, utf8d_core, utf8d_out_stage
`timescale 1ns / 1ps

module utf8_byte_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8d_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output utf8d_pkg::out_word_t m_data
);
    import utf8d_pkg::*;

    logic      hold_valid;
    in_word_t  hold_data;
    logic      out_free;
    logic      advance;
    logic      res_valid;
    out_word_t res_word;

    // held byte moves through decode when the result register can take it
    assign advance = hold_valid && out_free;

    utf8d_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    utf8d_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_word   (hold_data),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    utf8d_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .res_valid (res_valid),
        .res_word  (res_word),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
